// ----- hw/rtl/puct_pkg.sv -----
`timescale 1ns / 1ps

package puct_pkg;

	localparam int COUNT_BITS   = 20;
	localparam int PRIOR_BITS   = 16;
	localparam int GAIN_BITS    = 16;
	localparam int INDEX_BITS   = 9;
	localparam int MAX_CHILDREN = 512;
	localparam int CHILD_CNT_W  = $clog2(MAX_CHILDREN) + 1;
	localparam int SCORE_BITS   = 40;

	// Quotient of wins * 2^16 / visits
	localparam int Q_BITS       = COUNT_BITS + 16;
	// sqrt(N * 2^16) is sqrt(N) in Q.8
	localparam int RAD_BITS     = COUNT_BITS + 16;
	localparam int ROOT_BITS    = RAD_BITS / 2;
	localparam int SREM_BITS    = ROOT_BITS + 2;
	// gain * prior * root
	localparam int CP_BITS      = GAIN_BITS + PRIOR_BITS;
	localparam int PROD_BITS    = CP_BITS + ROOT_BITS;
	localparam int DVSR_BITS    = COUNT_BITS + 1;
	localparam int DVD_BITS     = PROD_BITS;
	localparam int EXPL_BITS    = PROD_BITS - 16;
	localparam int STEP_W       = $clog2(DVD_BITS + 1);

	localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(2560);
	localparam logic [Q_BITS-1:0]    Q_HALF     = Q_BITS'(32768);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RUN  = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_EDIV = 5'b01000,
		ST_CMP  = 5'b10000
	} state_t;

endpackage

// ----- hw/rtl/puct_child_select.sv -----
`timescale 1ns / 1ps

// PUCT child selection.
// Children of one node arrive one beat per child on the input channel
// (in_valid/in_ready). Each is scored as q + c*prior*sqrt(N)/(1+n), or the
// prior alone when the parent has no visits; the best one is kept, ties
// keeping the earliest. On the beat marked last one result beat leaves on
// the output channel (out_valid/out_ready) with the best child's index and
// a found flag; other beats give no result.
// After a child is accepted in_ready stays low through its states: a
// bit-serial restoring divider computes the 36-bit q (with the bit-pair
// square root running beside it), a multiply state follows, the same
// divider then runs over the 50-bit exploration dividend, and a compare
// state ends the child. The next child is accepted only once the previous
// one has left its compare state. The result of a last child is registered
// as the block leaves that compare state.
// A result is registered; the next child is accepted while it waits. If a
// second result is ready before the first is taken, the block holds in its
// compare cycle until out_ready.
// The exploration_gain write port (cfg_valid/cfg_ready) is always ready.
// Reset sets the gain to 10.0 (Q8.8), clears the running best and drops
// out_valid.
module puct_child_select (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [puct_pkg::GAIN_BITS-1:0]    exploration_gain,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [puct_pkg::COUNT_BITS-1:0]   parent_visits,
	input  logic [puct_pkg::COUNT_BITS-1:0]   child_wins,
	input  logic [puct_pkg::COUNT_BITS-1:0]   child_visits,
	input  logic [puct_pkg::PRIOR_BITS-1:0]   prior,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [puct_pkg::INDEX_BITS-1:0]   selected_index,
	output logic                              found
);
	import puct_pkg::*;

	state_t                  state_q;
	logic [GAIN_BITS-1:0]    gain_q;
	logic [STEP_W-1:0]       step_q;

	logic [COUNT_BITS-1:0]   pv_q;
	logic [COUNT_BITS-1:0]   n_q;
	logic [PRIOR_BITS-1:0]   prior_q;
	logic                    last_q;

	logic [DVD_BITS-1:0]     dvd_q;
	logic [DVSR_BITS-1:0]    rem_q;
	logic [DVSR_BITS-1:0]    dvsr_q;
	logic [Q_BITS-1:0]       quo_q;

	logic [RAD_BITS-1:0]     rad_q;
	logic [SREM_BITS-1:0]    srem_q;
	logic [ROOT_BITS-1:0]    root_q;
	logic [CP_BITS-1:0]      cp_q;

	logic [SCORE_BITS-1:0]   best_q;
	logic [INDEX_BITS-1:0]   best_pos_q;
	logic [CHILD_CNT_W-1:0]  count_q;
	logic                    have_best_q;

	logic                    out_valid_q;
	logic [INDEX_BITS-1:0]   sel_q;
	logic                    found_q;

	logic                    in_fire;
	logic [DVSR_BITS:0]      dtrial;
	logic                    dbit;
	logic [DVSR_BITS-1:0]    rem_nx;
	logic [SREM_BITS+1:0]    scur;
	logic [SREM_BITS+1:0]    strial;
	logic                    sbit;
	logic [SREM_BITS-1:0]    srem_nx;
	logic [Q_BITS-1:0]       q_val;
	logic [SCORE_BITS-1:0]   score;
	logic                    in_range;
	logic                    take;
	logic                    cmp_hold;
	logic                    res_load;

	assign cfg_ready      = 1'b1;
	assign in_ready       = (state_q == ST_IDLE);
	assign in_fire        = in_valid && in_ready;
	assign out_valid      = out_valid_q;
	assign selected_index = sel_q;
	assign found          = found_q;

	// One restoring division step
	always_comb begin
		dtrial = {rem_q, dvd_q[DVD_BITS-1]};
		dbit   = (dtrial >= {1'b0, dvsr_q});
		rem_nx = dbit ? DVSR_BITS'(dtrial - {1'b0, dvsr_q}) : dtrial[DVSR_BITS-1:0];
	end

	// One bit-pair square root step
	always_comb begin
		scur    = {srem_q, rad_q[RAD_BITS-1 -: 2]};
		strial  = (SREM_BITS+2)'({root_q, 2'b01});
		sbit    = (scur >= strial);
		srem_nx = sbit ? SREM_BITS'(scur - strial) : SREM_BITS'(scur);
	end

	// Score and best-child update
	always_comb begin
		q_val    = (n_q == '0) ? Q_HALF : quo_q;
		score    = (pv_q == '0) ? SCORE_BITS'(prior_q) :
			SCORE_BITS'(q_val) + SCORE_BITS'(dvd_q[DVD_BITS-1:16]);
		in_range = (count_q < CHILD_CNT_W'(MAX_CHILDREN));
		take     = in_range && (!have_best_q || score > best_q);
		cmp_hold = last_q && out_valid_q && !out_ready;
		res_load = (state_q == ST_CMP) && last_q && !cmp_hold;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_valid) begin
			gain_q <= exploration_gain;
		end
	end

	// Sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			best_q      <= '0;
			best_pos_q  <= '0;
			count_q     <= '0;
			have_best_q <= 1'b0;
			out_valid_q <= 1'b0;
			sel_q       <= '0;
			found_q     <= 1'b0;
		end else begin
			// raise a new result, else drop the result once taken
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(Q_BITS - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_EDIV;
					step_q  <= '0;
				end
				ST_EDIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DVD_BITS - 1)) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (!cmp_hold) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							found_q     <= have_best_q || in_range;
							sel_q       <= take ? count_q[INDEX_BITS-1:0] : best_pos_q;
							best_q      <= '0;
							best_pos_q  <= '0;
							count_q     <= '0;
							have_best_q <= 1'b0;
						end else begin
							if (take) begin
								best_q      <= score;
								best_pos_q  <= count_q[INDEX_BITS-1:0];
								have_best_q <= 1'b1;
							end
							if (in_range) begin
								count_q <= count_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: operands, divider, square root
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pv_q    <= parent_visits;
			n_q     <= child_visits;
			prior_q <= prior;
			last_q  <= last;
			dvd_q   <= {child_wins, 16'b0, (DVD_BITS-Q_BITS)'(0)};
			rem_q   <= '0;
			dvsr_q  <= DVSR_BITS'(child_visits);
			rad_q   <= {parent_visits, 16'b0};
			srem_q  <= '0;
			root_q  <= '0;
		end else if (state_q == ST_RUN) begin
			cp_q  <= gain_q * prior_q;
			dvd_q <= {dvd_q[DVD_BITS-2:0], dbit};
			rem_q <= rem_nx;
			// shift one root bit per step for the first half of the run
			if (step_q < STEP_W'(ROOT_BITS)) begin
				rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
				srem_q <= srem_nx;
				root_q <= {root_q[ROOT_BITS-2:0], sbit};
			end
		end else if (state_q == ST_MUL) begin
			quo_q  <= dvd_q[Q_BITS-1:0];
			dvd_q  <= cp_q * root_q;
			rem_q  <= '0;
			dvsr_q <= DVSR_BITS'(n_q) + 1'b1;
		end else if (state_q == ST_EDIV) begin
			dvd_q <= {dvd_q[DVD_BITS-2:0], dbit};
			rem_q <= rem_nx;
		end
	end

	// Checks
	a_no_found_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> selected_index == '0)
		else $error("result without a child carries a nonzero index");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CHILD_CNT_W'(MAX_CHILDREN))
		else $error("child count passed its limit");

	a_best_pos_seen: assert property (@(posedge clk) disable iff (!arst_n)
		have_best_q |-> CHILD_CNT_W'(best_pos_q) < count_q)
		else $error("best position beyond children scored");

	a_accept_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_RUN && !in_ready)
		else $error("accepted child did not start a run");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import puct_pkg::*;

	localparam int IDLE_LIMIT  = 20000;
	localparam int DRAIN_WAIT  = 200;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [PRIOR_BITS-1:0] PRIOR_MAX = '1;

	typedef struct packed {
		logic [COUNT_BITS-1:0] pv;
		logic [COUNT_BITS-1:0] wins;
		logic [COUNT_BITS-1:0] visits;
		logic [PRIOR_BITS-1:0] pr;
		logic                  lst;
	} child_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] idx;
		logic                  fnd;
	} pick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [GAIN_BITS-1:0] exploration_gain = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [COUNT_BITS-1:0] parent_visits = '0;
	logic [COUNT_BITS-1:0] child_wins = '0;
	logic [COUNT_BITS-1:0] child_visits = '0;
	logic [PRIOR_BITS-1:0] prior = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [INDEX_BITS-1:0] selected_index;
	logic found;

	puct_child_select dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .exploration_gain(exploration_gain),
		.in_valid(in_valid), .in_ready(in_ready),
		.parent_visits(parent_visits), .child_wins(child_wins),
		.child_visits(child_visits), .prior(prior), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.selected_index(selected_index), .found(found)
	);

	always #10 clk = ~clk;

	child_t child_q[$];
	pick_t  pick_q[$];
	int     send_idle = 0;
	int     recv_idle = 0;
	int     mismatches = 0;
	int     idle_cycles = 0;
	logic   in_beat = 1'b0;

	// model state
	logic [GAIN_BITS-1:0]  gain_m;
	logic [SCORE_BITS-1:0] top_score;
	int                    top_pos;
	int                    seen;
	logic                  have_top;

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [SCORE_BITS-1:0] puct_score(child_t c, logic [GAIN_BITS-1:0] g);
		logic [63:0] q;
		logic [63:0] prod;
		logic [63:0] s;
		if (c.pv == 0) return SCORE_BITS'(c.pr);
		q = (c.visits == 0) ? 64'd32768 : ({44'd0, c.wins} << 16) / c.visits;
		prod = 64'(g) * 64'(c.pr) * isqrt({44'd0, c.pv} << 16);
		s = q + ((prod / (64'(c.visits) + 1)) >> 16);
		if (s > {24'd0, {SCORE_BITS{1'b1}}}) s = {24'd0, {SCORE_BITS{1'b1}}};
		return s[SCORE_BITS-1:0];
	endfunction

	// score a child, close the set on last
	task automatic select_child(child_t c);
		logic [SCORE_BITS-1:0] s;
		pick_t p;
		if (seen < MAX_CHILDREN) begin
			s = puct_score(c, gain_m);
			if (!have_top || s > top_score) begin
				top_score = s;
				top_pos = seen;
				have_top = 1'b1;
			end
			seen++;
		end
		if (c.lst) begin
			p.idx = have_top ? INDEX_BITS'(top_pos) : '0;
			p.fnd = have_top;
			pick_q.push_back(p);
			top_score = '0;
			top_pos = 0;
			seen = 0;
			have_top = 1'b0;
		end
	endtask

	// monitor: track beats, predict, check results
	always @(posedge clk) begin
		in_beat <= in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) gain_m = exploration_gain;
			if (in_valid && in_ready)
				select_child({parent_visits, child_wins, child_visits, prior, last});
			if (out_valid && out_ready) begin
				if (pick_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result idx=%0d found=%0b", selected_index, found);
				end else begin
					if (pick_q[0].idx !== selected_index || pick_q[0].fnd !== found) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp idx=%0d found=%0b, got idx=%0d found=%0b",
								pick_q[0].idx, pick_q[0].fnd, selected_index, found);
					end
					void'(pick_q.pop_front());
				end
			end
		end
	end

	// watchdog: count cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// driver: advance to the next child once the current beat is taken
	always @(negedge clk) begin
		child_t c;
		out_ready <= ($urandom_range(99) >= recv_idle);
		if (!in_valid || in_beat) begin
			if (child_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				c = child_q.pop_front();
				{parent_visits, child_wins, child_visits, prior, last} <= c;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	function automatic logic [COUNT_BITS-1:0] pick_count();
		case ($urandom_range(5))
			0: return '0;
			1: return CNT_MAX;
			2: return COUNT_BITS'($urandom_range(16));
			3: return COUNT_BITS'($urandom_range(2000));
			default: return COUNT_BITS'($urandom);
		endcase
	endfunction

	function automatic child_t random_child(logic lst);
		child_t c;
		c.pv = ($urandom_range(7) == 0) ? '0 : pick_count();
		c.visits = pick_count();
		c.wins = ($urandom_range(3) == 0) ? pick_count()
			: COUNT_BITS'($urandom_range(0, c.visits));
		case ($urandom_range(3))
			0: c.pr = '0;
			1: c.pr = PRIOR_MAX;
			default: c.pr = PRIOR_BITS'($urandom);
		endcase
		c.lst = lst;
		return c;
	endfunction

	function automatic child_t mk(int pv, int w, int n, int p, logic lst);
		child_t c;
		c.pv = COUNT_BITS'(pv);
		c.wins = COUNT_BITS'(w);
		c.visits = COUNT_BITS'(n);
		c.pr = PRIOR_BITS'(p);
		c.lst = lst;
		return c;
	endfunction

	// queue random sets, mostly short, some single children
	task automatic queue_sets(int items);
		int n;
		while (items > 0) begin
			n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 10);
			for (int i = 0; i < n; i++) child_q.push_back(random_child(i == n - 1));
			items -= n;
		end
	endtask

	// hold until all children are in and every result is back
	task automatic drain();
		wait (child_q.size() == 0);
		@(posedge clk);
		while (in_valid || pick_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_gain(logic [GAIN_BITS-1:0] g);
		@(negedge clk);
		cfg_valid <= 1'b1;
		exploration_gain <= g;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		gain_m = GAIN_RESET;
		top_score = '0;
		top_pos = 0;
		seen = 0;
		have_top = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, unvisited parent, ties, wins above visits
		send_idle = 26;
		recv_idle = 64;
		child_q.push_back(mk(0, 0, 0, 100, 1'b0));
		child_q.push_back(mk(0, 5, 5, 65535, 1'b0));
		child_q.push_back(mk(0, 9, 9, 65535, 1'b1));
		child_q.push_back(mk(1048575, 1048575, 0, 65535, 1'b0));
		child_q.push_back(mk(1048575, 1048575, 1048575, 0, 1'b0));
		child_q.push_back(mk(1048575, 1048575, 1, 65535, 1'b1));
		child_q.push_back(mk(100, 7, 3, 1000, 1'b0));
		child_q.push_back(mk(100, 7, 3, 1000, 1'b0));
		child_q.push_back(mk(100, 7, 3, 1000, 1'b1));
		child_q.push_back(mk(1, 1048575, 2, 0, 1'b0));
		child_q.push_back(mk(1, 0, 0, 0, 1'b0));
		child_q.push_back(mk(1, 0, 1048575, 65535, 1'b1));
		child_q.push_back(mk(0, 0, 0, 0, 1'b1));
		child_q.push_back(mk(50, 10, 1048575, 1, 1'b0));
		child_q.push_back(mk(50, 60, 40, 0, 1'b1));
		drain();

		// gain at zero, then sender-idle swap
		write_gain('0);
		queue_sets(100);
		drain();
		send_idle = 64;
		recv_idle = 26;
		write_gain('1);
		queue_sets(100);
		drain();
		send_idle = 0;
		recv_idle = 0;
		write_gain(GAIN_BITS'($urandom));
		queue_sets(60);
		// oversized set: children past the limit are not scored
		for (int i = 0; i < MAX_CHILDREN + 4; i++)
			child_q.push_back(i == MAX_CHILDREN + 1 ? mk(1000, 1000, 1, 65535, 1'b0)
				: mk(1000, 10, 100, 10, i == MAX_CHILDREN + 3));
		drain();
		write_gain(GAIN_RESET);
		queue_sets(20);
		drain();

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
